### hw/rtl/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared types and constants for the segment / plane intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package spi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    // numerator and denominator of t, exact, in units of 2^-2F
    localparam int MAG_W     = 68;
    localparam int STEP_W    = MAG_W + 2;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = COORD_W;

    localparam logic [COORD_W-1:0] MISS_VALUE = {1'b0, {(COORD_W-1){1'b1}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X     = 2'd0,
        CFG_NORMAL_Y     = 2'd1,
        CFG_NORMAL_Z     = 2'd2,
        CFG_PLANE_OFFSET = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                          hit;
        logic [2:0][COORD_W-1:0]       s;
        logic [2:0]                    rneg;
        logic [2:0][COORD_W-1:0]       rm;
        logic [MAG_W-1:0]              an;
        logic [MAG_W-1:0]              ad;
        logic [2:0][COORD_W-1:0]       q;
        logic [2:0][MAG_W-1:0]         rem;
    } t_div_item;

endpackage

`default_nettype wire

### hw/rtl/spi_if.sv
// ----------------------------------------------------------------------------
// spi_if
// Valid/ready channels of the segment / plane intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

interface spi_seg_if;
    logic                                valid;
    logic                                ready;
    logic signed [spi_pkg::COORD_W-1:0]  start_x;
    logic signed [spi_pkg::COORD_W-1:0]  start_y;
    logic signed [spi_pkg::COORD_W-1:0]  start_z;
    logic signed [spi_pkg::COORD_W-1:0]  end_x;
    logic signed [spi_pkg::COORD_W-1:0]  end_y;
    logic signed [spi_pkg::COORD_W-1:0]  end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    output ready);
endinterface

interface spi_res_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic signed [spi_pkg::COORD_W-1:0]  cross_x;
    logic signed [spi_pkg::COORD_W-1:0]  cross_y;
    logic signed [spi_pkg::COORD_W-1:0]  cross_z;

    modport source (output valid, hit, cross_x, cross_y, cross_z, input ready);
    modport sink   (input valid, hit, cross_x, cross_y, cross_z, output ready);
endinterface

interface spi_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [spi_pkg::CFG_IDX_W-1:0]        index;
    logic [spi_pkg::COORD_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/spi_front.sv
// ----------------------------------------------------------------------------
// spi_front
// Plane registers, ray, dot products and hit test: four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_front #(
    parameter int FRAC_BITS = spi_pkg::FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    spi_seg_if.sink                 i_seg,
    spi_cfg_if.sink                 i_cfg,
    output spi_pkg::t_div_item      o_item,
    output logic                    o_valid,
    input  wire logic               i_ready
);

    localparam int CW = spi_pkg::COORD_W;
    localparam int DW = spi_pkg::DIFF_W;
    localparam int MW = spi_pkg::MAG_W;

    logic signed [CW-1:0] r_normal [3];
    logic signed [CW-1:0] r_plane_offset;

    logic [3:0] r_v;
    logic [3:0] rdy;

    // stage a: ray
    logic signed [CW-1:0]   r_a_s [3];
    logic signed [DW-1:0]   r_a_r [3];
    // stage b: products
    logic signed [CW-1:0]   r_b_s [3];
    logic signed [DW-1:0]   r_b_r [3];
    logic signed [2*CW-1:0] r_b_ps [3];
    logic signed [CW+DW-1:0] r_b_pr [3];
    logic signed [MW-1:0]   r_b_doff;
    // stage c: numerator and denominator
    logic signed [CW-1:0]   r_c_s [3];
    logic signed [DW-1:0]   r_c_r [3];
    logic signed [MW-1:0]   r_c_num;
    logic signed [MW-1:0]   r_c_den;
    // stage d
    spi_pkg::t_div_item     r_d;
    spi_pkg::t_div_item     n_d;

    logic signed [CW-1:0]   seg_s [3];
    logic signed [CW-1:0]   seg_e [3];
    logic signed [MW-1:0]   n_num;
    logic signed [MW-1:0]   n_den;
    logic signed [MW-1:0]   mag_num;
    logic signed [MW-1:0]   mag_den;
    logic signed [DW-1:0]   mag_r [3];
    logic                   den_zero;
    logic                   n_hit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal[0]    <= '0;
            r_normal[1]    <= '0;
            r_normal[2]    <= '0;
            r_plane_offset <= '0;
        end else if (i_cfg.valid) begin
            unique case (spi_pkg::t_cfg_idx'(i_cfg.index))
                spi_pkg::CFG_NORMAL_X:     r_normal[0]    <= i_cfg.data;
                spi_pkg::CFG_NORMAL_Y:     r_normal[1]    <= i_cfg.data;
                spi_pkg::CFG_NORMAL_Z:     r_normal[2]    <= i_cfg.data;
                spi_pkg::CFG_PLANE_OFFSET: r_plane_offset <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign rdy[3] = !r_v[3] || i_ready;
    assign rdy[2] = !r_v[2] || rdy[3];
    assign rdy[1] = !r_v[1] || rdy[2];
    assign rdy[0] = !r_v[0] || rdy[1];
    assign i_seg.ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_seg.valid;
            if (rdy[1]) r_v[1] <= r_v[0];
            if (rdy[2]) r_v[2] <= r_v[1];
            if (rdy[3]) r_v[3] <= r_v[2];
        end
    end

    assign seg_s[0] = i_seg.start_x;
    assign seg_s[1] = i_seg.start_y;
    assign seg_s[2] = i_seg.start_z;
    assign seg_e[0] = i_seg.end_x;
    assign seg_e[1] = i_seg.end_y;
    assign seg_e[2] = i_seg.end_z;

    always_comb begin
        n_num = -r_b_doff - MW'(r_b_ps[0]) - MW'(r_b_ps[1]) - MW'(r_b_ps[2]);
        n_den = MW'(r_b_pr[0]) + MW'(r_b_pr[1]) + MW'(r_b_pr[2]);
    end

    always_comb begin
        mag_num  = r_c_num[MW-1] ? -r_c_num : r_c_num;
        mag_den  = r_c_den[MW-1] ? -r_c_den : r_c_den;
        den_zero = (r_c_den == '0);
        // t in [0, 1] checked on signs, then on magnitudes
        if (den_zero) begin
            n_hit = 1'b0;
        end else if (!r_c_den[MW-1]) begin
            n_hit = !r_c_num[MW-1] && (r_c_num <= r_c_den);
        end else begin
            n_hit = (r_c_num >= r_c_den) && (r_c_num[MW-1] || r_c_num == '0);
        end
        n_d     = '0;
        n_d.hit = n_hit;
        n_d.an  = mag_num;
        n_d.ad  = mag_den;
        for (int c = 0; c < 3; c++) begin
            mag_r[c]     = r_c_r[c][DW-1] ? -r_c_r[c] : r_c_r[c];
            n_d.s[c]     = r_c_s[c];
            n_d.rneg[c]  = r_c_r[c][DW-1];
            n_d.rm[c]    = mag_r[c][CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int c = 0; c < 3; c++) begin
                r_a_s[c] <= seg_s[c];
                r_a_r[c] <= DW'(seg_e[c]) - DW'(seg_s[c]);
            end
        end
        if (rdy[1]) begin
            for (int c = 0; c < 3; c++) begin
                r_b_s[c]  <= r_a_s[c];
                r_b_r[c]  <= r_a_r[c];
                r_b_ps[c] <= r_normal[c] * r_a_s[c];
                r_b_pr[c] <= r_normal[c] * r_a_r[c];
            end
            r_b_doff <= MW'(r_plane_offset) <<< FRAC_BITS;
        end
        if (rdy[2]) begin
            r_c_s   <= r_b_s;
            r_c_r   <= r_b_r;
            r_c_num <= n_num;
            r_c_den <= n_den;
        end
        if (rdy[3]) begin
            r_d <= n_d;
        end
    end

    assign o_item  = r_d;
    assign o_valid = r_v[3];

`ifndef SYNTHESIS
    ap_hit_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && r_d.hit |-> (r_d.an <= r_d.ad) && (r_d.ad != '0))
        else $error("hit with numerator above denominator");
    ap_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && !i_ready |=> r_v[3] && $stable(r_d))
        else $error("stalled item changed at divider entry");
`endif

endmodule

`default_nettype wire

### hw/rtl/spi_div_stage.sv
// ----------------------------------------------------------------------------
// spi_div_stage
// One step of the scaled division q = rm * an / ad for all three axes.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_div_stage #(
    parameter int BIT = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  spi_pkg::t_div_item      i_item,
    input  wire logic               i_valid,
    output logic                    o_ready,
    output spi_pkg::t_div_item      o_item,
    output logic                    o_valid,
    input  wire logic               i_ready
);

    localparam int SW = spi_pkg::STEP_W;
    localparam int MW = spi_pkg::MAG_W;
    localparam int CW = spi_pkg::COORD_W;

    logic               r_valid;
    spi_pkg::t_div_item r_item;
    spi_pkg::t_div_item n_item;
    logic [SW-1:0]      part [3];
    logic [SW-1:0]      ad1;
    logic [SW-1:0]      ad2;

    assign o_ready = !r_valid || i_ready;

    // rem stays below ad; 2*rem + an is under 3*ad, so the digit is 0, 1 or 2
    always_comb begin
        n_item = i_item;
        ad1    = SW'(i_item.ad);
        ad2    = {1'b0, i_item.ad, 1'b0};
        for (int c = 0; c < 3; c++) begin
            part[c] = {1'b0, i_item.rem[c], 1'b0}
                      + (i_item.rm[c][BIT] ? SW'(i_item.an) : SW'(0));
            if (part[c] >= ad2) begin
                n_item.rem[c] = MW'(part[c] - ad2);
                n_item.q[c]   = {i_item.q[c][CW-2:0], 1'b0} + CW'(2);
            end else if (part[c] >= ad1) begin
                n_item.rem[c] = MW'(part[c] - ad1);
                n_item.q[c]   = {i_item.q[c][CW-2:0], 1'b1};
            end else begin
                n_item.rem[c] = MW'(part[c]);
                n_item.q[c]   = {i_item.q[c][CW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

`ifndef SYNTHESIS
    ap_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_item.hit |-> (r_item.rem[0] < r_item.ad)
            && (r_item.rem[1] < r_item.ad) && (r_item.rem[2] < r_item.ad))
        else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

### hw/rtl/spi_back.sv
// ----------------------------------------------------------------------------
// spi_back
// Signs the quotients, adds the start point and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  spi_pkg::t_div_item      i_item,
    input  wire logic               i_valid,
    output logic                    o_ready,
    spi_res_if.source               o_res
);

    localparam int CW = spi_pkg::COORD_W;

    logic          r_valid;
    logic          r_hit;
    logic [CW-1:0] r_cross [3];
    logic [CW-1:0] n_cross [3];
    logic [CW-1:0] offs [3];

    assign o_ready = !r_valid || o_res.ready;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            offs[c]    = i_item.rneg[c] ? -i_item.q[c] : i_item.q[c];
            n_cross[c] = i_item.hit ? i_item.s[c] + offs[c] : spi_pkg::MISS_VALUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_hit   <= i_item.hit;
            r_cross <= n_cross;
        end
    end

    assign o_res.valid   = r_valid;
    assign o_res.hit     = r_hit;
    assign o_res.cross_x = r_cross[0];
    assign o_res.cross_y = r_cross[1];
    assign o_res.cross_z = r_cross[2];

`ifndef SYNTHESIS
    ap_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_hit |-> (r_cross[0] == spi_pkg::MISS_VALUE)
            && (r_cross[1] == spi_pkg::MISS_VALUE) && (r_cross[2] == spi_pkg::MISS_VALUE))
        else $error("miss without saturated coordinates");
`endif

endmodule

`default_nettype wire

### hw/rtl/segment_plane_intersection.sv
// ----------------------------------------------------------------------------
// segment_plane_intersection
// Fixed-point segment against plane test with the meeting point.
// ----------------------------------------------------------------------------
// Takes one segment per cycle while the output is not stalled and returns one
// result per segment, in order: four stages form the ray, the dot products
// and the hit test, 32 stages run one step each of the exact scaled division
// (one quotient bit per stage, all three axes side by side), and one stage
// adds the start point into the output register. The plane is written through
// the configuration channel while no segment is in flight; the user must keep
// to this, the block does not enforce it. A parallel or degenerate segment is
// a miss, and a miss returns all coordinates at the largest positive value.
`default_nettype none

module segment_plane_intersection #(
    parameter int FRAC_BITS = spi_pkg::FRAC_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spi_seg_if.sink     i_seg,
    spi_cfg_if.sink     i_cfg,
    spi_res_if.source   o_res
);

    localparam int STEPS = spi_pkg::DIV_STEPS;

    spi_pkg::t_div_item item  [STEPS+1];
    logic               valid [STEPS+1];
    logic               ready [STEPS+1];

    spi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (i_seg),
        .i_cfg   (i_cfg),
        .o_item  (item[0]),
        .o_valid (valid[0]),
        .i_ready (ready[0])
    );

    // quotient bits from the top down
    for (genvar k = 0; k < STEPS; k++) begin : g_div
        spi_div_stage #(
            .BIT (STEPS - 1 - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (item[k]),
            .i_valid (valid[k]),
            .o_ready (ready[k]),
            .o_item  (item[k+1]),
            .o_valid (valid[k+1]),
            .i_ready (ready[k+1])
        );
    end

    spi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item[STEPS]),
        .i_valid (valid[STEPS]),
        .o_ready (ready[STEPS]),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
